// ----- hdl/ftss_pkg.sv -----
package ftss_pkg;

    // Sequencer phases, in the order the move runs through them
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_Y_OUT  = 3'd1,
        PH_X_OUT  = 3'd2,
        PH_PAUSE1 = 3'd3,
        PH_Y_BACK = 3'd4,
        PH_X_BACK = 3'd5,
        PH_PAUSE2 = 3'd6,
        PH_SPARE  = 3'd7
    } phase_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_SCALE_X       = 3'd2,
        CFG_SCALE_Y       = 3'd3,
        CFG_STEP_LIMIT    = 3'd4,
        CFG_HALF_PERIOD_X = 3'd5,
        CFG_HALF_PERIOD_Y = 3'd6,
        CFG_PAUSE_TICKS   = 3'd7
    } cfg_index_t;

    // Item kinds carried on the input tuser bit
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] FRAME_HEADER  = 8'hA5;
    localparam logic [7:0] FRAME_TRAILER = 8'h5B;

    localparam int CFG_DATA_W = 22;
    localparam int TICK_W     = 18;

    localparam logic [7:0]  RST_ORIGIN_X      = 8'd15;
    localparam logic [7:0]  RST_ORIGIN_Y      = 8'd60;
    localparam logic [21:0] RST_SCALE_X       = 22'd860052;
    localparam logic [21:0] RST_SCALE_Y       = 22'd1147739;
    localparam logic [11:0] RST_STEP_LIMIT    = 12'd2000;
    localparam logic [15:0] RST_HALF_PERIOD_X = 16'd1000;
    localparam logic [15:0] RST_HALF_PERIOD_Y = 16'd650;
    localparam logic [17:0] RST_PAUSE_TICKS   = 18'd200000;

    // One result item; step_x_pin sits in the lowest bit
    typedef struct packed {
        logic frame_error;
        logic busy_res;
        logic dir_y_pin;
        logic step_y_pin;
        logic dir_x_pin;
        logic step_x_pin;
    } result_t;

    function automatic phase_t next_phase(phase_t p);
        phase_t r;
        if (p == PH_PAUSE2 || p == PH_IDLE || p == PH_SPARE) begin
            r = PH_IDLE;
        end else begin
            r = phase_t'(3'(p) + 3'd1);
        end
        return r;
    endfunction

endpackage

// ----- hdl/framed_target_stepper_sequencer.sv -----
// Framed target stepper sequencer. Each input transfer is either a received byte
// (s_tuser = 0, byte in s_tdata) or a one-microsecond tick (s_tuser = 1), and each
// produces exactly one result transfer carrying the step/direction pin levels, busy
// and a one-shot frame error. Bytes are gathered in groups of four; a group with
// header A5 and trailer 5B starts a move to target x/y: Y out, X out, pause, Y back,
// X back, pause, each step lasting two half periods of ticks. Bytes arriving during a
// move are dropped and restart framing. Registers on the cfg port are read live and
// may only be written while no result is pending. Throughput is one item per clock
// while s_tready is high: the whole state update, including the two 8x22
// step-count multiplies on the closing byte of a frame, happens in the cycle of
// the input transfer. The result is registered in a two-entry output buffer
// (result register plus skid register) that keeps s_tready high while one result
// waits, so the input only stalls when two results are held back by the sink.
module framed_target_stepper_sequencer #(
    parameter int STEP_WIDTH = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] step_x_pin, [1] dir_x_pin, [2] step_y_pin,
                                   // [3] dir_y_pin, [4] busy_res, [5] frame_error, [7:6] 0
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [ftss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ftss_pkg::*;

    localparam int CMP_W = (STEP_WIDTH > 14) ? STEP_WIDTH : 14;
    localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'((64'd1 << STEP_WIDTH) - 64'd1);

    typedef struct packed {
        phase_t                phase;
        logic [STEP_WIDTH-1:0] steps_left;
        logic                  pulse;
        logic [1:0]            dir;
    } enter_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0]  origin_x_reg, origin_y_reg;
    logic [21:0] scale_x_reg, scale_y_reg;
    logic [11:0] step_limit_reg;
    logic [15:0] half_period_x_reg, half_period_y_reg;
    logic [17:0] pause_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg      <= RST_ORIGIN_X;
            origin_y_reg      <= RST_ORIGIN_Y;
            scale_x_reg       <= RST_SCALE_X;
            scale_y_reg       <= RST_SCALE_Y;
            step_limit_reg    <= RST_STEP_LIMIT;
            half_period_x_reg <= RST_HALF_PERIOD_X;
            half_period_y_reg <= RST_HALF_PERIOD_Y;
            pause_ticks_reg   <= RST_PAUSE_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ORIGIN_X:      origin_x_reg      <= cfg_wdata[7:0];
                CFG_ORIGIN_Y:      origin_y_reg      <= cfg_wdata[7:0];
                CFG_SCALE_X:       scale_x_reg       <= cfg_wdata[21:0];
                CFG_SCALE_Y:       scale_y_reg       <= cfg_wdata[21:0];
                CFG_STEP_LIMIT:    step_limit_reg    <= cfg_wdata[11:0];
                CFG_HALF_PERIOD_X: half_period_x_reg <= cfg_wdata[15:0];
                CFG_HALF_PERIOD_Y: half_period_y_reg <= cfg_wdata[15:0];
                CFG_PAUSE_TICKS:   pause_ticks_reg   <= cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    logic [1:0]            byte_count_reg, byte_count_next;
    logic [7:0]            frame_bytes_reg [3];
    logic [7:0]            frame_bytes_next [3];
    phase_t                phase_reg, phase_next;
    logic [STEP_WIDTH-1:0] steps_x_total_reg, steps_x_total_next;
    logic [STEP_WIDTH-1:0] steps_y_total_reg, steps_y_total_next;
    logic [STEP_WIDTH-1:0] steps_left_reg, steps_left_next;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic                  pulse_high_reg, pulse_high_next;
    logic [1:0]            dir_bits_reg, dir_bits_next;
    logic                  frame_error_next;

    // Enter a phase, passing through step phases with no steps and empty pauses.
    // Direction pins flip when a return phase is entered, even if it is skipped.
    function automatic enter_t enter_phase(phase_t p_in, logic [STEP_WIDTH-1:0] ny,
                                           logic [STEP_WIDTH-1:0] nx, logic pause_nz,
                                           logic [1:0] dir_in);
        enter_t r;
        phase_t p;
        logic   done;
        p            = p_in;
        done         = 1'b0;
        r.phase      = PH_IDLE;
        r.steps_left = '0;
        r.pulse      = 1'b0;
        r.dir        = dir_in;
        for (int i = 0; i < 7; i++) begin
            if (!done) begin
                if (p == PH_Y_BACK) r.dir[1] = ~r.dir[1];
                if (p == PH_X_BACK) r.dir[0] = ~r.dir[0];
                case (p) inside
                    PH_Y_OUT, PH_Y_BACK: begin
                        if (ny != '0) begin
                            r.steps_left = ny;
                            r.pulse      = 1'b1;
                            r.phase      = p;
                            done         = 1'b1;
                        end
                    end
                    PH_X_OUT, PH_X_BACK: begin
                        if (nx != '0) begin
                            r.steps_left = nx;
                            r.pulse      = 1'b1;
                            r.phase      = p;
                            done         = 1'b1;
                        end
                    end
                    PH_PAUSE1, PH_PAUSE2: begin
                        if (pause_nz) begin
                            r.phase = p;
                            done    = 1'b1;
                        end
                    end
                    default: begin
                        r.phase = PH_IDLE;
                        done    = 1'b1;
                    end
                endcase
                p = next_phase(p);
            end
        end
        return r;
    endfunction

    // Distance times 6.16 scale, truncated, clamped to step_limit and counter range
    function automatic logic [STEP_WIDTH-1:0] axis_steps(logic [7:0] target,
                                                         logic [7:0] origin,
                                                         logic [21:0] scale,
                                                         logic [11:0] limit);
        logic [7:0]       d;
        logic [29:0]      prod;
        logic [13:0]      s;
        logic [CMP_W-1:0] c;
        d    = (target >= origin) ? (target - origin) : (origin - target);
        prod = 30'(d) * 30'(scale);
        s    = prod[29:16];
        if (s > 14'(limit)) begin
            s = 14'(limit);
        end
        c = CMP_W'(s);
        if (c > STEP_MAX) begin
            c = STEP_MAX;
        end
        return c[STEP_WIDTH-1:0];
    endfunction

    logic                  in_fire;
    logic [TICK_W-1:0]     tick_inc;
    logic [STEP_WIDTH-1:0] steps_dec;
    logic [15:0]           half_limit;
    logic                  frame_ok;
    logic [STEP_WIDTH-1:0] new_x, new_y;
    logic [1:0]            new_dir;
    enter_t                ent;

    assign tick_inc   = tick_count_reg + TICK_W'(1);
    assign steps_dec  = (steps_left_reg != '0) ? steps_left_reg - STEP_WIDTH'(1)
                                               : steps_left_reg;
    assign half_limit = (phase_reg == PH_Y_OUT || phase_reg == PH_Y_BACK)
                        ? half_period_y_reg : half_period_x_reg;
    assign frame_ok   = (frame_bytes_reg[0] == FRAME_HEADER) && (s_tdata == FRAME_TRAILER);
    assign new_x      = axis_steps(frame_bytes_reg[1], origin_x_reg, scale_x_reg,
                                   step_limit_reg);
    assign new_y      = axis_steps(frame_bytes_reg[2], origin_y_reg, scale_y_reg,
                                   step_limit_reg);
    assign new_dir    = {frame_bytes_reg[2] >= origin_y_reg, frame_bytes_reg[1] < origin_x_reg};

    // Next state for one accepted item
    always_comb begin
        byte_count_next    = byte_count_reg;
        frame_bytes_next   = frame_bytes_reg;
        phase_next         = phase_reg;
        steps_x_total_next = steps_x_total_reg;
        steps_y_total_next = steps_y_total_reg;
        steps_left_next    = steps_left_reg;
        tick_count_next    = tick_count_reg;
        pulse_high_next    = pulse_high_reg;
        dir_bits_next      = dir_bits_reg;
        frame_error_next   = 1'b0;
        ent                = enter_phase(PH_IDLE, steps_y_total_reg, steps_x_total_reg,
                                         1'b0, dir_bits_reg);

        if (s_tuser == OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                if (phase_reg == PH_PAUSE1 || phase_reg == PH_PAUSE2) begin
                    if (tick_inc >= pause_ticks_reg) begin
                        // pause over: advance to the next phase
                        ent = enter_phase(next_phase(phase_reg), steps_y_total_reg,
                                          steps_x_total_reg, pause_ticks_reg != '0,
                                          dir_bits_reg);
                        phase_next      = ent.phase;
                        steps_left_next = ent.steps_left;
                        pulse_high_next = ent.pulse;
                        dir_bits_next   = ent.dir;
                        tick_count_next = '0;
                    end else begin
                        tick_count_next = tick_inc;
                    end
                end else if (tick_inc < TICK_W'(half_limit)) begin
                    tick_count_next = tick_inc;
                end else begin
                    tick_count_next = '0;
                    if (pulse_high_reg) begin
                        // falling edge ends one step
                        pulse_high_next = 1'b0;
                        steps_left_next = steps_dec;
                        if (steps_dec == '0) begin
                            ent = enter_phase(next_phase(phase_reg), steps_y_total_reg,
                                              steps_x_total_reg, pause_ticks_reg != '0,
                                              dir_bits_reg);
                            phase_next      = ent.phase;
                            steps_left_next = ent.steps_left;
                            pulse_high_next = ent.pulse;
                            dir_bits_next   = ent.dir;
                        end
                    end else begin
                        pulse_high_next = 1'b1;
                    end
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            // drop the byte and restart framing
            byte_count_next = '0;
        end else if (byte_count_reg != 2'd3) begin
            for (int i = 0; i < 3; i++) begin
                if (byte_count_reg == 2'(i)) begin
                    frame_bytes_next[i] = s_tdata;
                end
            end
            byte_count_next = byte_count_reg + 2'd1;
        end else begin
            byte_count_next = '0;
            if (frame_ok) begin
                ent = enter_phase(PH_Y_OUT, new_y, new_x, pause_ticks_reg != '0, new_dir);
                steps_x_total_next = new_x;
                steps_y_total_next = new_y;
                phase_next         = ent.phase;
                steps_left_next    = ent.steps_left;
                pulse_high_next    = ent.pulse;
                dir_bits_next      = ent.dir;
                tick_count_next    = '0;
            end else begin
                frame_error_next = 1'b1;
            end
        end
    end

    // Result fields, taken from the state after the item
    result_t res_next;

    always_comb begin
        res_next.step_x_pin  = pulse_high_next &&
                               (phase_next == PH_X_OUT || phase_next == PH_X_BACK);
        res_next.dir_x_pin   = dir_bits_next[0];
        res_next.step_y_pin  = pulse_high_next &&
                               (phase_next == PH_Y_OUT || phase_next == PH_Y_BACK);
        res_next.dir_y_pin   = dir_bits_next[1];
        res_next.busy_res    = phase_next != PH_IDLE;
        res_next.frame_error = frame_error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= '0;
            frame_bytes_reg   <= '{default: '0};
            phase_reg         <= PH_IDLE;
            steps_x_total_reg <= '0;
            steps_y_total_reg <= '0;
            steps_left_reg    <= '0;
            tick_count_reg    <= '0;
            pulse_high_reg    <= 1'b0;
            dir_bits_reg      <= '0;
        end else if (in_fire) begin
            byte_count_reg    <= byte_count_next;
            frame_bytes_reg   <= frame_bytes_next;
            phase_reg         <= phase_next;
            steps_x_total_reg <= steps_x_total_next;
            steps_y_total_reg <= steps_y_total_next;
            steps_left_reg    <= steps_left_next;
            tick_count_reg    <= tick_count_next;
            pulse_high_reg    <= pulse_high_next;
            dir_bits_reg      <= dir_bits_next;
        end
    end

    // ---------------------------------------------------------------
    // Output buffer: result register plus skid register
    // ---------------------------------------------------------------
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    out_fire;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // input is held off; drain the skid entry into the result register
            if (out_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_fire) begin
            out_valid_reg <= in_fire;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || out_fire) begin
            if (in_fire) begin
                out_reg <= res_next;
            end
        end else if (in_fire) begin
            skid_reg <= res_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in front of it");

    a_one_axis_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[2]))
        else $error("x and y step pins high together");

    a_error_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5]) |-> !m_tdata[4])
        else $error("frame error reported during a move");

    a_y_steps_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_Y_OUT || phase_reg == PH_Y_BACK)
        |-> (steps_left_reg != '0 && steps_left_reg <= steps_y_total_reg))
        else $error("y step count out of range");

    a_x_steps_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_X_OUT || phase_reg == PH_X_BACK)
        |-> (steps_left_reg != '0 && steps_left_reg <= steps_x_total_reg))
        else $error("x step count out of range");

endmodule

// ----- bench/framed_target_stepper_sequencer_test.sv -----
module framed_target_stepper_sequencer_test;

    import ftss_pkg::*;

    localparam int STEP_W      = 12;
    localparam int STEP_MAX    = (1 << STEP_W) - 1;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORK  = 45;

    localparam result_t RES_QUIET = '0;
    localparam result_t RES_BAD   = result_t'(6'b100000);

    // One row of the directed plan: reprogram the registers first when set,
    // and pin the expected pins when the levels are obvious at a glance
    typedef struct packed {
        logic       reprogram;
        logic       op;
        logic [7:0] data;
        logic       pinned;
        result_t    want;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] rx_byte
    logic                  s_tuser;   // [0] operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [0] step_x_pin, [1] dir_x_pin, [2] step_y_pin,
                                      // [3] dir_y_pin, [4] busy_res, [5] frame_error
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Sideband that travels with the input transfer: a pinned expectation
    logic    item_pinned;
    result_t item_want;

    // Shadow registers of the block
    logic [7:0]  org_x, org_y;
    logic [21:0] scl_x, scl_y;
    logic [11:0] lim;
    logic [15:0] hp_x, hp_y;
    logic [17:0] pause_len;

    // Shadow sequencer state
    logic [1:0]        bytes_seen;
    logic [7:0]        held [0:2];
    phase_t            seq_phase;
    logic [STEP_W-1:0] count_x, count_y, left;
    logic [17:0]       ticks;
    logic              pulse;
    logic [1:0]        dirs;      // bit 0 = x pin, bit 1 = y pin

    result_t pin_levels_due [$];
    int      fault_count  = 0;
    int      work_done    = 0;
    int      quiet_cycles = 0;
    int      burst_left   = 0;
    int      stall_left   = 0;
    int      stall_mode   = 0;
    int      spread       = 255;
    logic    frames_barred = 1'b0;

    plan_row_t steps_plan [0:19] = '{
        // reset settings: idle tick, two broken groups with extreme bytes
        {1'b0, OP_TICK, 8'h00, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'h00, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'hFF, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'h80, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'h5B, 1'b1, RES_BAD},
        {1'b0, OP_BYTE, 8'hA5, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'hFF, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'h00, 1'b1, RES_QUIET},
        {1'b0, OP_BYTE, 8'h00, 1'b1, RES_BAD},
        {1'b0, OP_TICK, 8'hFF, 1'b1, RES_QUIET},
        // short settings: x one step toward lower x, y empty, zero x half period
        {1'b1, OP_BYTE, 8'hA5, 1'b0, RES_QUIET},
        {1'b0, OP_BYTE, 8'h09, 1'b0, RES_QUIET},
        {1'b0, OP_BYTE, 8'h0A, 1'b0, RES_QUIET},
        {1'b0, OP_BYTE, 8'h5B, 1'b0, RES_QUIET},
        {1'b0, OP_TICK, 8'h00, 1'b0, RES_QUIET},
        {1'b0, OP_BYTE, 8'h33, 1'b0, RES_QUIET},   // byte during the move: drop
        {1'b0, OP_TICK, 8'h00, 1'b0, RES_QUIET},
        {1'b0, OP_TICK, 8'h00, 1'b0, RES_QUIET},
        {1'b0, OP_TICK, 8'h00, 1'b0, RES_QUIET},
        {1'b0, OP_TICK, 8'h00, 1'b0, RES_QUIET}
    };

    framed_target_stepper_sequencer #(
        .STEP_WIDTH(STEP_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    task automatic load_reset_state();
        org_x      = RST_ORIGIN_X;
        org_y      = RST_ORIGIN_Y;
        scl_x      = RST_SCALE_X;
        scl_y      = RST_SCALE_Y;
        lim        = RST_STEP_LIMIT;
        hp_x       = RST_HALF_PERIOD_X;
        hp_y       = RST_HALF_PERIOD_Y;
        pause_len  = RST_PAUSE_TICKS;
        bytes_seen = '0;
        held[0]    = '0;
        held[1]    = '0;
        held[2]    = '0;
        seq_phase  = PH_IDLE;
        count_x    = '0;
        count_y    = '0;
        left       = '0;
        ticks      = '0;
        pulse      = 1'b0;
        dirs       = '0;
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (cfg_index_t'(idx))
            CFG_ORIGIN_X:      org_x     = val[7:0];
            CFG_ORIGIN_Y:      org_y     = val[7:0];
            CFG_SCALE_X:       scl_x     = val[21:0];
            CFG_SCALE_Y:       scl_y     = val[21:0];
            CFG_STEP_LIMIT:    lim       = val[11:0];
            CFG_HALF_PERIOD_X: hp_x      = val[15:0];
            CFG_HALF_PERIOD_Y: hp_y      = val[15:0];
            CFG_PAUSE_TICKS:   pause_len = val[17:0];
            default: ;
        endcase
    endtask

    // Distance times the 6.16 factor, integer part, clamped to the limit
    // and to the counter width
    function automatic logic [STEP_W-1:0] count_steps(input logic [7:0] tgt,
                                                      input logic [7:0] org,
                                                      input logic [21:0] scl);
        logic [7:0]  span;
        logic [29:0] prod;
        logic [13:0] whole;
        span  = (tgt >= org) ? tgt - org : org - tgt;
        prod  = 30'(span) * 30'(scl);
        whole = prod[29:16];
        if (whole > 14'(lim)) whole = 14'(lim);
        if (whole > 14'(STEP_MAX)) whole = 14'(STEP_MAX);
        return whole[STEP_W-1:0];
    endfunction

    // Enter a phase; skip step phases with no steps and pauses of zero length
    task automatic begin_phase(input phase_t start);
        phase_t            p;
        logic              settled;
        logic [STEP_W-1:0] n;
        p       = start;
        settled = 1'b0;
        while (!settled) begin
            ticks = '0;
            pulse = 1'b0;
            if (p == PH_Y_BACK) dirs[1] = ~dirs[1];
            if (p == PH_X_BACK) dirs[0] = ~dirs[0];
            case (p)
                PH_Y_OUT, PH_Y_BACK, PH_X_OUT, PH_X_BACK: begin
                    n = (p == PH_Y_OUT || p == PH_Y_BACK) ? count_y : count_x;
                    if (n != 0) begin
                        left      = n;
                        pulse     = 1'b1;
                        seq_phase = p;
                        settled   = 1'b1;
                    end
                end
                PH_PAUSE1, PH_PAUSE2: begin
                    if (pause_len != 0) begin
                        left      = '0;
                        seq_phase = p;
                        settled   = 1'b1;
                    end
                end
                default: begin
                    left      = '0;
                    seq_phase = PH_IDLE;
                    settled   = 1'b1;
                end
            endcase
            if (!settled) p = (p == PH_PAUSE2) ? PH_IDLE : phase_t'(p + 3'd1);
        end
    endtask

    task automatic on_tick();
        logic [15:0] half;
        if (seq_phase == PH_IDLE) return;
        ticks = ticks + 18'd1;
        if (seq_phase == PH_PAUSE1 || seq_phase == PH_PAUSE2) begin
            if (ticks >= pause_len)
                begin_phase(seq_phase == PH_PAUSE2 ? PH_IDLE : PH_Y_BACK);
            return;
        end
        half = (seq_phase == PH_Y_OUT || seq_phase == PH_Y_BACK) ? hp_y : hp_x;
        if (ticks < half) return;
        ticks = '0;
        if (pulse) begin
            // falling edge closes one step
            pulse = 1'b0;
            if (left > 0) left = left - STEP_W'(1);
            if (left == 0) begin_phase(phase_t'(seq_phase + 3'd1));
        end else begin
            pulse = 1'b1;
        end
    endtask

    task automatic advance_stepper(input logic op, input logic [7:0] b, output result_t r);
        logic err;
        err = 1'b0;
        if (op == OP_TICK) begin
            on_tick();
        end else if (seq_phase != PH_IDLE) begin
            bytes_seen = '0;
        end else if (bytes_seen < 2'd3) begin
            held[bytes_seen] = b;
            bytes_seen       = bytes_seen + 2'd1;
        end else begin
            bytes_seen = '0;
            if (held[0] == FRAME_HEADER && b == FRAME_TRAILER) begin
                count_x = count_steps(held[1], org_x, scl_x);
                count_y = count_steps(held[2], org_y, scl_y);
                dirs    = {held[2] >= org_y, held[1] < org_x};
                begin_phase(PH_Y_OUT);
            end else begin
                err = 1'b1;
            end
        end
        r.step_x_pin  = pulse && (seq_phase == PH_X_OUT || seq_phase == PH_X_BACK);
        r.dir_x_pin   = dirs[0];
        r.step_y_pin  = pulse && (seq_phase == PH_Y_OUT || seq_phase == PH_Y_BACK);
        r.dir_y_pin   = dirs[1];
        r.busy_res    = seq_phase != PH_IDLE;
        r.frame_error = err;
    endtask

    // ---------------------------------------------------------------
    // Sampling: every accepted transfer is handled here at the clock edge,
    // reading the values that the block itself saw at that edge
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s expected %0b got %0b", $time, name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge aclk) begin : sample_edges
        result_t want;
        result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) begin
                advance_stepper(s_tuser, s_tdata, want);
                work_done++;
                pin_levels_due.push_back(item_pinned ? item_want : want);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[5:0]);
                if (pin_levels_due.size() == 0) begin
                    $display("%0t: result expected none got %02h", $time, m_tdata);
                    fault_count++;
                end else begin
                    want = pin_levels_due.pop_front();
                    check_field("step_x_pin", want.step_x_pin, got.step_x_pin);
                    check_field("dir_x_pin", want.dir_x_pin, got.dir_x_pin);
                    check_field("step_y_pin", want.step_y_pin, got.step_y_pin);
                    check_field("dir_y_pin", want.dir_y_pin, got.dir_y_pin);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("frame_error", want.frame_error, got.frame_error);
                    check_field("pad[6]", 1'b0, m_tdata[6]);
                    check_field("pad[7]", 1'b0, m_tdata[7]);
                end
            end
        end
    end

    // Watchdog: end the run if no transfer moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: switch between randomly chosen stall patterns
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= (stall_left[1:0] != 2'd0);
        endcase
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------

    // Offer one item; return at the edge where it is accepted. Valid stays
    // high on return so that back-to-back items need no second assignment.
    task automatic offer_item(input logic op, input logic [7:0] b,
                              input logic pinned, input result_t want);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        // keep frames from forming while long settings are loaded
        if (frames_barred && op == OP_BYTE && b == FRAME_HEADER) b = FRAME_HEADER - 8'd1;
        s_tvalid    <= 1'b1;
        s_tuser     <= op;
        s_tdata     <= b;
        item_pinned <= pinned;
        item_want   <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer_item(OP_BYTE, b, 1'b0, RES_QUIET);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) offer_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, RES_QUIET);
    endtask

    // Hold the sender until every expected result has arrived
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pin_levels_due.size() != 0) @(posedge aclk);
    endtask

    // Tick the running move to its end so that the registers can change
    task automatic settle();
        wait_drain();
        while (seq_phase != PH_IDLE) begin
            send_ticks(20);
            wait_drain();
        end
    endtask

    task automatic load_registers(input logic [7:0] ox, input logic [7:0] oy,
                                  input logic [21:0] sx, input logic [21:0] sy,
                                  input logic [11:0] sl, input logic [15:0] hx,
                                  input logic [15:0] hy, input logic [17:0] pz);
        logic [CFG_DATA_W-1:0] vals [0:7];
        vals[CFG_ORIGIN_X]      = CFG_DATA_W'(ox);
        vals[CFG_ORIGIN_Y]      = CFG_DATA_W'(oy);
        vals[CFG_SCALE_X]       = sx;
        vals[CFG_SCALE_Y]       = sy;
        vals[CFG_STEP_LIMIT]    = CFG_DATA_W'(sl);
        vals[CFG_HALF_PERIOD_X] = CFG_DATA_W'(hx);
        vals[CFG_HALF_PERIOD_Y] = CFG_DATA_W'(hy);
        vals[CFG_PAUSE_TICKS]   = CFG_DATA_W'(pz);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Target near the origin when the spread is narrow, anywhere otherwise
    function automatic logic [7:0] pick_target(input logic [7:0] org);
        int v;
        if (spread >= 255) return 8'($urandom_range(0, 255));
        v = int'(org);
        v = v + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic logic [21:0] pick_scale();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 22'($urandom_range(0, 1 << 16));
            2:       return 22'($urandom_range(0, 1 << 18));
            default: return 22'($urandom_range(0, 4194303));
        endcase
    endfunction

    // One random action: half the time whole frames followed by ticks, the rest
    // broken groups, stray bytes, tick runs and an occasional full drain
    task automatic random_action();
        int          pick;
        logic [7:0]  hd, tr;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_byte(FRAME_HEADER);
            send_byte(pick_target(org_x));
            send_byte(pick_target(org_y));
            send_byte(FRAME_TRAILER);
            send_ticks($urandom_range(0, 40));
        end else if (pick < 65) begin
            hd = 8'($urandom_range(0, 255));
            tr = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) begin
                if (tr == FRAME_TRAILER) tr = ~tr;
            end else begin
                if (hd == FRAME_HEADER) hd = ~hd;
            end
            send_byte(hd);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(tr);
        end else if (pick < 80) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 98) begin
            send_ticks($urandom_range(1, 40));
        end else begin
            wait_drain();
        end
    endtask

    // Load the registers for one random phase; the kinds cover both ends of
    // every register while keeping the moves short enough to finish
    task automatic setup_phase(input int idx);
        frames_barred = 1'b0;
        spread        = 255;
        case (idx)
            1: begin
                // widest scales, widest limit, fastest stepping, no pauses
                spread = 1;
                load_registers(8'd0, 8'd255, 22'h3FFFFF, 22'h3FFFFF, 12'd4095,
                               16'd1, 16'd1, 18'd0);
            end
            3: begin
                // every phase empty: frames pass straight back to idle
                load_registers(8'd255, 8'd0, 22'd0, 22'd0, 12'd0, 16'hFFFF, 16'hFFFF,
                               18'd0);
            end
            5: begin
                // longest timing loaded; keep moves from starting at all
                frames_barred = 1'b1;
                load_registers(8'd128, 8'd127, 22'h3FFFFF, 22'h3FFFFF, 12'd4095,
                               16'hFFFF, 16'hFFFF, 18'h3FFFF);
            end
            default: begin
                load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               pick_scale(), pick_scale(), 12'($urandom_range(0, 8)),
                               16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                               18'($urandom_range(0, 4)));
            end
        endcase
    endtask

    initial begin
        int goal;
        load_reset_state();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = OP_BYTE;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        item_pinned = 1'b0;
        item_want   = RES_QUIET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan
        foreach (steps_plan[i]) begin
            if (steps_plan[i].reprogram) begin
                settle();
                load_registers(8'd10, 8'd10, 22'h010000, 22'h010000, 12'd4095,
                               16'd0, 16'hFFFF, 18'd1);
            end
            offer_item(steps_plan[i].op, steps_plan[i].data,
                       steps_plan[i].pinned, steps_plan[i].want);
        end

        // Random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            setup_phase(ph);
            goal = work_done + PHASE_WORK;
            while (work_done < goal) random_action();
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
